>>> design/assert_macros.svh
// assertion macros shared by the morse line decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clk edge outside reset
`define MLD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("morse line decoder assertion failed");
// condition that must never hold outside reset
`define MLD_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("morse line decoder forbidden condition seen");
`else
`define MLD_ASSERT(label, prop)
`define MLD_NEVER(label, cond)
`endif

`endif

>>> design/mld_pkg.sv
// shared constants, types and the letter table of the morse line decoder
`default_nettype none

package mld_pkg;

	localparam int MAX_SYMBOLS = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
	localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
	localparam int THR_W       = 8;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	typedef logic signed [COUNT_WIDTH-1:0] cnt_t;

	localparam cnt_t COUNT_MAX = cnt_t'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);
	localparam cnt_t COUNT_MIN = cnt_t'(64'd1 << (COUNT_WIDTH - 1));

	// register indexes, byte address is four times the index
	localparam logic [2:0] REG_INPUT_ENABLE = 3'd0;
	localparam logic [2:0] REG_DOT_MIN      = 3'd1;
	localparam logic [2:0] REG_DASH_MIN     = 3'd2;
	localparam logic [2:0] REG_LETTER_GAP   = 3'd3;
	localparam logic [2:0] REG_WORD_GAP     = 3'd4;

	localparam logic [7:0] CHAR_QMARK = 8'h3f;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [THR_W-1:0] DOT_MIN_RST    = 8'd2;
	localparam logic [THR_W-1:0] DASH_MIN_RST   = 8'd10;
	localparam logic [THR_W-1:0] LETTER_GAP_RST = 8'd6;
	localparam logic [THR_W-1:0] WORD_GAP_RST   = 8'd26;

	localparam int LETTER_ENTRIES = 30;

	// letters for lengths one to four, offset by two to the length minus two
	localparam logic [7:0] LETTER_TABLE [LETTER_ENTRIES] = '{
		"e", "t",
		"i", "n", "a", "m",
		"s", "d", "r", "g", "u", "k", "w", "o",
		"h", "b", "l", "z", "f", "c", "p", "?",
		"v", "x", "?", "q", "?", "y", "j", "?"
	};

	typedef struct packed {
		logic             input_enable;
		logic [THR_W-1:0] dot_min;
		logic [THR_W-1:0] dash_min;
		logic [THR_W-1:0] letter_gap;
		logic [THR_W-1:0] word_gap;
	} mld_cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_code;
		logic [3:0] raw_length;
		logic [7:0] raw_pattern;
	} mld_result_t;

	function automatic logic [7:0] decode_letter(
		input logic [MAX_SYMBOLS-1:0] bits,
		input logic [SYM_CNT_W-1:0]   count,
		input logic                   overflow
	);
		logic [2:0] len;
		logic [4:0] span;
		logic [4:0] idx;
		logic [7:0] ch;
		len  = count[2:0];
		span = 5'd1 << len;
		idx  = span - 5'd2 + (5'(bits[3:0]) & (span - 5'd1));
		if (overflow || count == '0 || count > SYM_CNT_W'(4)) begin
			ch = CHAR_QMARK;
		end else if (idx >= 5'(LETTER_ENTRIES)) begin
			ch = CHAR_QMARK;
		end else begin
			ch = LETTER_TABLE[idx];
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

>>> design/morse_line_decoder_core.sv
// Morse line decoder, top level.
// Input channel: in_valid/in_stall carry one line_level sample per beat, a
// sample every quarter of a Morse unit. Output channel: out_valid/out_stall
// carry char_code, raw_length and raw_pattern, at most one beat per sample:
// a letter ('?' when unknown) when a low run reaches the letter gap, a space
// when it reaches the word gap.
// Each sample is taken into the input register, its result into the output
// register. Throughput is one sample per cycle unless the receiver stalls: the
// run counter update and letter table lookup sit between those registers.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more sample; in_stall rises only once both are full.
// Thresholds and the enable sit in APB registers at byte addresses 0 to 16,
// written while the block is idle; pready is always high.
// Reset clears the run counter and stored symbols, empties both registers and
// loads the default thresholds (enable 1, dot 2, dash 10, gaps 6 and 26).
`default_nettype none
`include "assert_macros.svh"

module morse_line_decoder_core
	import mld_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              line_level,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        char_code,
	output logic      [3:0]        raw_length,
	output logic      [7:0]        raw_pattern
);

	mld_cfg_t    cfg;
	mld_result_t result;
	logic        valid_s1;
	logic        level_s1;
	logic        blocked;
	logic        advance;
	logic        accept;
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic [3:0]  length_q;
	logic [7:0]  pattern_q;

	assign pready = 1'b1;

	mld_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign blocked  = out_valid_q && out_stall;
	assign advance  = valid_s1 && !blocked;
	assign in_stall = valid_s1 && blocked;
	assign accept   = in_valid && !in_stall;

	mld_sym_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.level  (level_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			char_q    <= result.char_code;
			length_q  <= result.raw_length;
			pattern_q <= result.raw_pattern;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_code   = char_q;
	assign raw_length  = length_q;
	assign raw_pattern = pattern_q;

	`MLD_ASSERT(a_stall_needs_sample, in_stall |-> valid_s1 && out_valid_q)
	`MLD_ASSERT(a_space_is_empty, (out_valid && char_code == CHAR_SPACE) |-> (raw_length == 4'd0 && raw_pattern == 8'd0))
	`MLD_ASSERT(a_empty_is_gap, (out_valid && raw_length == 4'd0) |-> (char_code == CHAR_SPACE || char_code == CHAR_QMARK))
	`MLD_NEVER(a_length_range, out_valid && raw_length > 4'(MAX_SYMBOLS))

endmodule

`default_nettype wire

>>> design/mld_cfg_regs.sv
// apb register file holding the decoder thresholds and enable
`default_nettype none

module mld_cfg_regs
	import mld_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output mld_cfg_t               cfg
);

	mld_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_enable <= 1'b1;
			cfg_q.dot_min      <= DOT_MIN_RST;
			cfg_q.dash_min     <= DASH_MIN_RST;
			cfg_q.letter_gap   <= LETTER_GAP_RST;
			cfg_q.word_gap     <= WORD_GAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_INPUT_ENABLE: cfg_q.input_enable <= pwdata[0];
				REG_DOT_MIN:      cfg_q.dot_min      <= pwdata[THR_W-1:0];
				REG_DASH_MIN:     cfg_q.dash_min     <= pwdata[THR_W-1:0];
				REG_LETTER_GAP:   cfg_q.letter_gap   <= pwdata[THR_W-1:0];
				REG_WORD_GAP:     cfg_q.word_gap     <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INPUT_ENABLE: prdata = DATA_W'(cfg_q.input_enable);
			REG_DOT_MIN:      prdata = DATA_W'(cfg_q.dot_min);
			REG_DASH_MIN:     prdata = DATA_W'(cfg_q.dash_min);
			REG_LETTER_GAP:   prdata = DATA_W'(cfg_q.letter_gap);
			REG_WORD_GAP:     prdata = DATA_W'(cfg_q.word_gap);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> design/mld_sym_engine.sv
// run counter, symbol store and letter decode, one sample per cycle while step is high
`default_nettype none
`include "assert_macros.svh"

module mld_sym_engine
	import mld_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mld_cfg_t cfg,
	input  wire logic     step,
	input  wire logic     level,
	output mld_result_t   result
);

	cnt_t                   run_q;
	logic [MAX_SYMBOLS-1:0] bits_q;
	logic [SYM_CNT_W-1:0]   count_q;
	logic                   overflow_q;

	cnt_t                   run_d;
	cnt_t                   run_tmp;
	logic [MAX_SYMBOLS-1:0] bits_d;
	logic [SYM_CNT_W-1:0]   count_d;
	logic                   overflow_d;
	logic                   store;
	logic                   is_dash;
	cnt_t                   dot_thr;
	cnt_t                   dash_thr;
	cnt_t                   letter_thr;
	cnt_t                   word_thr;

	assign dot_thr    = cnt_t'(cfg.dot_min);
	assign dash_thr   = cnt_t'(cfg.dash_min);
	assign letter_thr = -cnt_t'(cfg.letter_gap);
	assign word_thr   = -cnt_t'(cfg.word_gap);

	always_comb begin
		run_d      = run_q;
		run_tmp    = run_q;
		bits_d     = bits_q;
		count_d    = count_q;
		overflow_d = overflow_q;
		store      = 1'b0;
		is_dash    = 1'b0;
		result     = '0;
		if (step && cfg.input_enable) begin
			if (level) begin
				// a high after a low run restarts from zero
				if (run_q < 0) begin
					run_tmp = '0;
				end
				run_d = (run_tmp < COUNT_MAX) ? run_tmp + cnt_t'(1) : run_tmp;
			end else begin
				if (run_q >= dash_thr) begin
					store   = 1'b1;
					is_dash = 1'b1;
					run_tmp = '0;
				end else if (run_q >= dot_thr) begin
					store   = 1'b1;
					run_tmp = '0;
				end else if (run_q == letter_thr) begin
					result.valid       = 1'b1;
					result.char_code   = decode_letter(bits_q, count_q, overflow_q);
					result.raw_length  = 4'(count_q);
					result.raw_pattern = 8'(bits_q);
					bits_d             = '0;
					count_d            = '0;
					overflow_d         = 1'b0;
				end else if (run_q == word_thr) begin
					result.valid     = 1'b1;
					result.char_code = CHAR_SPACE;
					bits_d           = '0;
					count_d          = '0;
					overflow_d       = 1'b0;
				end
				if (store) begin
					if (count_q < SYM_CNT_W'(MAX_SYMBOLS)) begin
						bits_d[count_q[SYM_IDX_W-1:0]] = is_dash;
						count_d = count_q + SYM_CNT_W'(1);
					end else begin
						overflow_d = 1'b1;
					end
				end
				run_d = (run_tmp > COUNT_MIN) ? run_tmp - cnt_t'(1) : run_tmp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			bits_q     <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			run_q      <= run_d;
			bits_q     <= bits_d;
			count_q    <= count_d;
			overflow_q <= overflow_d;
		end
	end

	`MLD_ASSERT(a_count_bounded, count_q <= SYM_CNT_W'(MAX_SYMBOLS))
	`MLD_ASSERT(a_overflow_full, overflow_q |-> count_q == SYM_CNT_W'(MAX_SYMBOLS))
	`MLD_ASSERT(a_store_resets_run, store |=> run_q == -cnt_t'(1))

endmodule

`default_nettype wire

>>> verif/mld_checker.sv
// beat monitor, line decoder predictor and result comparison for the morse line decoder
`timescale 1ns / 1ps

module mld_checker
	import mld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              line_level,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        char_code,
	input  logic [3:0]        raw_length,
	input  logic [7:0]        raw_pattern,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [7:0] char_code;
		logic [3:0] raw_length;
		logic [7:0] raw_pattern;
	} decoded_t;

	localparam int RUN_TOP    = (1 << (COUNT_WIDTH - 1)) - 1;
	localparam int RUN_BOTTOM = -RUN_TOP - 1;
	// lengths one to four, each length starts at two to the length minus two
	localparam logic [8*30-1:0] MORSE_ALPHABET = "etinamsdrgukwohblzfcp?vx?q?yj?";

	mld_cfg_t               cfg;
	int                     run_len;
	logic [MAX_SYMBOLS-1:0] sym_bits;
	int                     sym_count;
	logic                   sym_dropped;
	decoded_t               expected_chars[$];
	decoded_t               seen;
	decoded_t               want;

	task automatic report_mismatch(input string msg);
		$display("[%0t] decoder mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void clear_letter();
		sym_bits    = '0;
		sym_count   = 0;
		sym_dropped = 1'b0;
	endfunction

	function automatic void hold_symbol(input logic is_dash);
		if (sym_count < MAX_SYMBOLS) begin
			if (is_dash) begin
				sym_bits[sym_count] = 1'b1;
			end
			sym_count++;
		end else begin
			sym_dropped = 1'b1;
		end
	endfunction

	function automatic logic [7:0] letter_now();
		int idx;
		if (sym_dropped || sym_count == 0 || sym_count > 4) begin
			return CHAR_QMARK;
		end
		idx = (1 << sym_count) - 2 + int'(sym_bits & ((1 << sym_count) - 1));
		return MORSE_ALPHABET[8*(29-idx) +: 8];
	endfunction

	// advances the decoder by one line sample, returns 1 when a character comes out
	function automatic bit take_sample(input logic level, output decoded_t res);
		bit got;
		got = 1'b0;
		res = '0;
		if (!cfg.input_enable) begin
			return 1'b0;
		end
		if (level) begin
			if (run_len < 0) begin
				run_len = 0;
			end
			if (run_len < RUN_TOP) begin
				run_len++;
			end
			return 1'b0;
		end
		if (run_len >= int'(cfg.dash_min)) begin
			hold_symbol(1'b1);
			run_len = 0;
		end else if (run_len >= int'(cfg.dot_min)) begin
			hold_symbol(1'b0);
			run_len = 0;
		end else if (run_len == -int'(cfg.letter_gap)) begin
			res = '{letter_now(), 4'(sym_count), sym_bits};
			clear_letter();
			got = 1'b1;
		end else if (run_len == -int'(cfg.word_gap)) begin
			res = '{CHAR_SPACE, 4'd0, 8'd0};
			clear_letter();
			got = 1'b1;
		end
		if (run_len > RUN_BOTTOM) begin
			run_len--;
		end
		return got;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{input_enable: 1'b1, dot_min: DOT_MIN_RST, dash_min: DASH_MIN_RST,
				letter_gap: LETTER_GAP_RST, word_gap: WORD_GAP_RST};
			run_len = 0;
			clear_letter();
			expected_chars.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_INPUT_ENABLE: cfg.input_enable = pwdata[0];
					REG_DOT_MIN:      cfg.dot_min      = pwdata[THR_W-1:0];
					REG_DASH_MIN:     cfg.dash_min     = pwdata[THR_W-1:0];
					REG_LETTER_GAP:   cfg.letter_gap   = pwdata[THR_W-1:0];
					REG_WORD_GAP:     cfg.word_gap     = pwdata[THR_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = '{char_code, raw_length, raw_pattern};
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("beat with nothing expected, char %02h len %0d pat %02h",
						seen.char_code, seen.raw_length, seen.raw_pattern));
				end else begin
					want = expected_chars.pop_front();
					if (seen.char_code !== want.char_code) begin
						report_mismatch($sformatf("char_code %02h, expected %02h",
							seen.char_code, want.char_code));
					end
					if (seen.raw_length !== want.raw_length) begin
						report_mismatch($sformatf("raw_length %0d, expected %0d",
							seen.raw_length, want.raw_length));
					end
					if (seen.raw_pattern !== want.raw_pattern) begin
						report_mismatch($sformatf("raw_pattern %02h, expected %02h",
							seen.raw_pattern, want.raw_pattern));
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (take_sample(line_level, want)) begin
					expected_chars.push_back(want);
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

>>> verif/tb_morse_line_decoder_core.sv
// stimulus, handshake pacing and verdict for the morse line decoder regression
`timescale 1ns / 1ps

module tb_morse_line_decoder_core;
	import mld_pkg::*;

	localparam int HOLD_CYCLES = 400;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [ADDR_W-1:0] paddr      = '0;
	logic [DATA_W-1:0] pwdata     = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic              line_level = 1'b0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [7:0]        char_code;
	logic [3:0]        raw_length;
	logic [7:0]        raw_pattern;

	int fail_count;
	int pending;
	int sent_samples   = 0;
	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_request   = 1'b0;

	// thresholds as last written, used to shape the keying
	int dot_len    = int'(DOT_MIN_RST);
	int dash_len   = int'(DASH_MIN_RST);
	int letter_gap = int'(LETTER_GAP_RST);
	int word_gap   = int'(WORD_GAP_RST);

	morse_line_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.raw_length (raw_length),
		.raw_pattern(raw_pattern)
	);

	mld_checker decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.raw_length (raw_length),
		.raw_pattern(raw_pattern),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("morse_line_decoder_core regression: fail");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_sample(input logic level);
		if (sender_idles && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		line_level <= level;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_samples++;
	endtask

	task automatic send_run(input logic level, input int count);
		repeat (count) send_sample(level);
	endtask

	// keys one letter given as dots and dashes, exact or with jittered run lengths
	task automatic key_pattern(input string marks, input bit jitter);
		int len;
		int hi;
		for (int i = 0; i < marks.len(); i++) begin
			if (marks[i] == "-") begin
				len = jitter ? $urandom_range(dash_len, dash_len + 3) : dash_len;
			end else begin
				hi  = dash_len > dot_len ? dash_len - 1 : dot_len;
				len = jitter ? $urandom_range(dot_len, hi) : dot_len;
			end
			send_run(1'b1, len);
			if (i < marks.len() - 1) begin
				len = jitter ? $urandom_range(1, letter_gap) : 1;
			end else if (jitter && $urandom_range(0, 3) == 0) begin
				len = word_gap + $urandom_range(1, 4);
			end else begin
				len = letter_gap + 1 + (jitter ? $urandom_range(0, 2) : 0);
			end
			send_run(1'b0, len);
		end
	endtask

	task automatic random_traffic(input int count);
		int    stop_at;
		int    nsym;
		string marks;
		stop_at = sent_samples + count;
		while (sent_samples < stop_at) begin
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 12)) send_sample($urandom_range(0, 1) != 0);
				1: send_run(1'b0, word_gap + $urandom_range(1, 5));
				default: begin
					nsym  = $urandom_range(0, 9) == 0 ? $urandom_range(6, 10) : $urandom_range(1, 5);
					marks = "";
					repeat (nsym) begin
						if ($urandom_range(0, 1) != 0) begin
							marks = {marks, "-"};
						end else begin
							marks = {marks, "."};
						end
					end
					key_pattern(marks, 1'b1);
				end
			endcase
		end
	endtask

	// drops valid and lets the pipeline empty before register writes or the verdict
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0 && waited < 3000) begin
			@(posedge clk);
			waited++;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] index, input int unsigned value, input int width);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({index, 2'b00});
		pwdata  <= ($urandom() << width) | value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_timing(input int dot, input int dash, input int lgap, input int wgap);
		reg_write(REG_DOT_MIN, dot, THR_W);
		reg_write(REG_DASH_MIN, dash, THR_W);
		reg_write(REG_LETTER_GAP, lgap, THR_W);
		reg_write(REG_WORD_GAP, wgap, THR_W);
		dot_len    = dot;
		dash_len   = dash;
		letter_gap = lgap;
		word_gap   = wgap;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: empty letter then space, edge run lengths, odd patterns
		send_run(1'b0, 27);
		key_pattern(".", 1'b0);
		key_pattern("-", 1'b0);
		send_run(1'b1, 9);
		send_run(1'b0, 7);
		send_run(1'b1, 1);
		send_run(1'b0, 7);
		key_pattern("-.-.", 1'b0);
		key_pattern(".....", 1'b0);
		key_pattern("---.", 1'b0);
		key_pattern(".........", 1'b0);
		key_pattern("---------", 1'b0);
		key_pattern("--.-", 1'b0);
		send_run(1'b0, 30);

		// long receiver hold while letters keep coming
		settle();
		hold_request = 1'b1;
		repeat (12) key_pattern(".", 1'b0);
		random_traffic(250);

		settle();
		set_timing(1, 2, 1, 3);
		random_traffic(200);

		// equal gaps decode the letter only
		settle();
		set_timing(3, 6, 4, 4);
		key_pattern("-..", 1'b0);
		send_run(1'b0, 10);
		random_traffic(150);

		settle();
		set_timing(1, 255, 255, 255);
		key_pattern(".-.", 1'b0);
		send_run(1'b0, 30);

		// samples while disabled leave the decoder untouched
		settle();
		reg_write(REG_INPUT_ENABLE, 0, 1);
		set_timing(2, 10, 6, 26);
		key_pattern("-", 1'b0);
		repeat (60) send_sample($urandom_range(0, 1) != 0);
		settle();
		reg_write(REG_INPUT_ENABLE, 1, 1);
		key_pattern(".-", 1'b0);

		// dash shorter than dot, word gap shorter than letter gap, no idling from here
		settle();
		set_timing(5, 1, 9, 3);
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		random_traffic(200);

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("morse_line_decoder_core regression: pass");
		end else begin
			$display("morse_line_decoder_core regression: fail");
		end
		$finish;
	end

endmodule
